/* hw/rtl/lpb_pkg.sv */
// ---------------------------------------------------------------------------
// lpb_pkg
// Types and constants shared by the character LCD progress bar blocks.
// ---------------------------------------------------------------------------
package lpb_pkg;

    localparam int PROGRESS_W      = 16;
    localparam int LEN_W           = 5;
    localparam int GLYPH_W         = 3;
    localparam int POS_W           = 4;
    localparam int MAX_CELLS       = 16;
    localparam int PIXELS_PER_CELL = 5;
    localparam int PIXEL_W         = 7;
    localparam int NUM_W           = 23;
    localparam int STEP_W          = 5;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [GLYPH_W-1:0] GLYPH_EMPTY = 3'd0;
    localparam logic [GLYPH_W-1:0] GLYPH_FULL  = 3'd5;

    typedef struct packed {
        logic [PROGRESS_W-1:0] progress;
        logic [PROGRESS_W-1:0] full_scale;
        logic [LEN_W-1:0]      bar_length;
    } lpb_req_t;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph_code;
        logic [POS_W-1:0]   cell_position;
        logic               last_cell;
    } lpb_glyph_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixels;
        logic [LEN_W-1:0]   length;
    } lpb_job_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_MUL,
        FS_DIV,
        FS_PUSH
    } lpb_front_state_t;

endpackage

/* hw/rtl/lcd_progress_bar_cells.sv */
// A zero maximum skips the divider; otherwise the front runs the 23-step serial divider.
// The front takes a new request only after it has pushed the last one into the queue;
// the emitter then gives one glyph per cycle while glyph_ready holds, one glyph per cell.
// Requests with a zero length are dropped and give no glyphs.
// Reset (rst_n, asynchronous, active low) empties the job queue and output register.
// ---------------------------------------------------------------------------
// lcd_progress_bar_cells
// Character LCD progress bar: glyph code for each cell of a bar.
// ---------------------------------------------------------------------------
module lcd_progress_bar_cells
#(
    parameter int QUEUE_DEPTH = lpb_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  lpb_pkg::lpb_req_t     req,
    output logic                  glyph_valid,
    input  logic                  glyph_ready,
    output lpb_pkg::lpb_glyph_t   glyph
);

    logic                 push_valid, push_ready;
    lpb_pkg::lpb_job_t    push_job;
    logic                 pop_valid, pop_ready;
    lpb_pkg::lpb_job_t    pop_job;

    lpb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    lpb_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    lpb_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (pop_valid),
        .job_ready   (pop_ready),
        .job         (pop_job),
        .glyph_valid (glyph_valid),
        .glyph_ready (glyph_ready),
        .glyph       (glyph)
    );

endmodule

/* hw/rtl/lpb_front.sv */
// ---------------------------------------------------------------------------
// lpb_front
// Accept a request, saturate the length and compute the filled pixel count
// with a multiply and a bit-serial restoring divider, or a full bar when the maximum is zero.
// ---------------------------------------------------------------------------
module lpb_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  lpb_pkg::lpb_req_t     req,
    output logic                  push_valid,
    input  logic                  push_ready,
    output lpb_pkg::lpb_job_t     push_job
);

    lpb_pkg::lpb_front_state_t           state_reg, state_next;
    logic [lpb_pkg::PROGRESS_W-1:0]      prog_reg, prog_next;
    logic [lpb_pkg::PROGRESS_W-1:0]      maxp_reg, maxp_next;
    logic [lpb_pkg::LEN_W-1:0]           len_reg, len_next;
    logic [lpb_pkg::NUM_W-1:0]           num_reg, num_next;
    logic [lpb_pkg::PROGRESS_W-1:0]      rem_reg, rem_next;
    logic [lpb_pkg::STEP_W-1:0]          step_reg, step_next;

    logic [lpb_pkg::LEN_W-1:0]           len_sat;
    logic [lpb_pkg::PIXEL_W-1:0]         total;
    logic [lpb_pkg::PROGRESS_W:0]        trial;
    logic [lpb_pkg::PROGRESS_W:0]        diff;
    logic                                ge;
    logic [lpb_pkg::PIXEL_W-1:0]         pixels;

    always_comb
    begin
        len_sat = (req.bar_length > lpb_pkg::LEN_W'(lpb_pkg::MAX_CELLS)) ?
                  lpb_pkg::LEN_W'(lpb_pkg::MAX_CELLS) : req.bar_length;
        total   = lpb_pkg::PIXEL_W'(len_reg) * lpb_pkg::PIXEL_W'(lpb_pkg::PIXELS_PER_CELL);
        trial   = {rem_reg, num_reg[lpb_pkg::NUM_W-1]};
        ge      = (trial >= {1'b0, maxp_reg});
        diff    = trial - {1'b0, maxp_reg};
        pixels  = (num_reg > lpb_pkg::NUM_W'(total)) ? total : num_reg[lpb_pkg::PIXEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpb_pkg::FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prog_reg <= prog_next;
        maxp_reg <= maxp_next;
        len_reg  <= len_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

    always_comb
    begin
        state_next = state_reg;
        prog_next  = prog_reg;
        maxp_next  = maxp_reg;
        len_next   = len_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        req_ready  = 1'b0;
        push_valid = 1'b0;
        push_job   = '{pixels: pixels, length: len_reg};

        unique case (state_reg)
            lpb_pkg::FS_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    prog_next = req.progress;
                    maxp_next = req.full_scale;
                    len_next  = len_sat;
                    if (len_sat != '0)
                    begin
                        state_next = lpb_pkg::FS_MUL;
                    end
                end
            end
            lpb_pkg::FS_MUL:
            begin
                rem_next  = '0;
                step_next = '0;
                if (maxp_reg == '0)
                begin
                    num_next   = lpb_pkg::NUM_W'(total);
                    state_next = lpb_pkg::FS_PUSH;
                end
                else
                begin
                    num_next   = lpb_pkg::NUM_W'(prog_reg) * lpb_pkg::NUM_W'(total);
                    state_next = lpb_pkg::FS_DIV;
                end
            end
            lpb_pkg::FS_DIV:
            begin
                rem_next  = ge ? diff[lpb_pkg::PROGRESS_W-1:0] : trial[lpb_pkg::PROGRESS_W-1:0];
                num_next  = {num_reg[lpb_pkg::NUM_W-2:0], ge};
                step_next = step_reg + 1'b1;
                if (step_reg == lpb_pkg::STEP_W'(lpb_pkg::NUM_W - 1))
                begin
                    state_next = lpb_pkg::FS_PUSH;
                end
            end
            lpb_pkg::FS_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = lpb_pkg::FS_IDLE;
                end
            end
            default:
            begin
                state_next = lpb_pkg::FS_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/lpb_queue.sv */
// ---------------------------------------------------------------------------
// lpb_queue
// Short job queue between the divider front and the cell emitter.
// ---------------------------------------------------------------------------
module lpb_queue
#(
    parameter int DEPTH = lpb_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  lpb_pkg::lpb_job_t     push_job,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output lpb_pkg::lpb_job_t     pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lpb_pkg::lpb_job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    always_comb
    begin
        push_ready  = (count_reg != CNT_W'(DEPTH));
        pop_valid   = (count_reg != '0);
        pop_job     = mem_reg[rd_ptr_reg];
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hw/rtl/lpb_back.sv */
// ---------------------------------------------------------------------------
// lpb_back
// Emit one glyph code per cell from a pixel count, into an output register.
// ---------------------------------------------------------------------------
module lpb_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  lpb_pkg::lpb_job_t     job,
    output logic                  glyph_valid,
    input  logic                  glyph_ready,
    output lpb_pkg::lpb_glyph_t   glyph
);

    logic                              busy_reg, busy_next;
    logic                              out_valid_reg, out_valid_next;
    lpb_pkg::lpb_glyph_t               out_reg, out_next;
    logic [lpb_pkg::PIXEL_W-1:0]       rem_reg, rem_next;
    logic [lpb_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [lpb_pkg::POS_W-1:0]         last_reg, last_next;
    logic [lpb_pkg::LEN_W-1:0]         len_m1;
    logic                              step;
    logic                              full_cell;

    always_comb
    begin
        len_m1         = job.length - 1'b1;
        step           = busy_reg && (!out_valid_reg || glyph_ready);
        full_cell      = (rem_reg >= lpb_pkg::PIXEL_W'(lpb_pkg::PIXELS_PER_CELL));
        job_ready      = !busy_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;

        if (!busy_reg)
        begin
            if (job_valid)
            begin
                busy_next = 1'b1;
                rem_next  = job.pixels;
                pos_next  = '0;
                last_next = len_m1[lpb_pkg::POS_W-1:0];
            end
        end
        if (step)
        begin
            out_valid_next         = 1'b1;
            out_next.cell_position = pos_reg;
            out_next.last_cell     = (pos_reg == last_reg);
            if (full_cell)
            begin
                out_next.glyph_code = lpb_pkg::GLYPH_FULL;
                rem_next = rem_reg - lpb_pkg::PIXEL_W'(lpb_pkg::PIXELS_PER_CELL);
            end
            else if (rem_reg == '0)
            begin
                out_next.glyph_code = lpb_pkg::GLYPH_EMPTY;
            end
            else
            begin
                out_next.glyph_code = rem_reg[lpb_pkg::GLYPH_W-1:0];
                rem_next = '0;
            end
            pos_next = pos_reg + 1'b1;
            if (pos_reg == last_reg)
            begin
                busy_next = 1'b0;
            end
        end
        else if (out_valid_reg && glyph_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        rem_reg  <= rem_next;
        pos_reg  <= pos_next;
        last_reg <= last_next;
    end

    assign glyph_valid = out_valid_reg;
    assign glyph       = out_reg;

endmodule

/* dv/lcd_progress_bar_cells_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lcd_progress_bar_cells_tb
// Sends progress bar requests through the valid/ready request channel,
// works out the glyph expected for each cell of every accepted request,
// and checks each glyph the block hands back against the oldest expected
// one. Both channels idle at random in most phases; one phase stalls the glyph side long
// enough for the block to fill up and hold off new requests.
// ---------------------------------------------------------------------------

class glyph_ledger;
    lpb_pkg::lpb_glyph_t  pending_glyphs[$];
    int unsigned          errors;

    task report(string what);
        $display("%0t ns  mismatch: %s", $time, what);
        errors++;
    endtask

    function void note_request(lpb_pkg::lpb_req_t r);
        int unsigned          cells;
        int unsigned          span;
        int unsigned          filled;
        int unsigned          first_px;
        lpb_pkg::lpb_glyph_t  g;
        cells = (r.bar_length > lpb_pkg::MAX_CELLS) ? lpb_pkg::MAX_CELLS : r.bar_length;
        span  = cells * lpb_pkg::PIXELS_PER_CELL;
        if (r.full_scale == 0)
            filled = span;
        else
        begin
            filled = (32'(r.progress) * span) / 32'(r.full_scale);
            if (filled > span)
                filled = span;
        end
        for (int unsigned c = 0; c < cells; c++)
        begin
            first_px = c * lpb_pkg::PIXELS_PER_CELL;
            if (first_px + lpb_pkg::PIXELS_PER_CELL <= filled)
                g.glyph_code = lpb_pkg::GLYPH_FULL;
            else if (first_px > filled)
                g.glyph_code = lpb_pkg::GLYPH_EMPTY;
            else
                g.glyph_code = lpb_pkg::GLYPH_W'(filled % lpb_pkg::PIXELS_PER_CELL);
            g.cell_position = lpb_pkg::POS_W'(c);
            g.last_cell     = (c + 1 == cells);
            pending_glyphs.push_back(g);
        end
    endfunction

    task check_glyph(lpb_pkg::lpb_glyph_t got);
        lpb_pkg::lpb_glyph_t want;
        if (pending_glyphs.size() == 0)
        begin
            report($sformatf("glyph %0d at cell %0d with nothing pending",
                             got.glyph_code, got.cell_position));
            return;
        end
        want = pending_glyphs.pop_front();
        if (got.glyph_code !== want.glyph_code)
            report($sformatf("glyph_code %0d, wanted %0d at cell %0d",
                             got.glyph_code, want.glyph_code, want.cell_position));
        if (got.cell_position !== want.cell_position)
            report($sformatf("cell_position %0d, wanted %0d",
                             got.cell_position, want.cell_position));
        if (got.last_cell !== want.last_cell)
            report($sformatf("last_cell %0d, wanted %0d at cell %0d",
                             got.last_cell, want.last_cell, want.cell_position));
    endtask

    task close_out();
        if (pending_glyphs.size() != 0)
            report($sformatf("%0d glyphs never arrived", pending_glyphs.size()));
    endtask
endclass

module lcd_progress_bar_cells_tb;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    lpb_pkg::lpb_req_t    req;
    logic                 glyph_valid;
    logic                 glyph_ready;
    lpb_pkg::lpb_glyph_t  glyph;

    glyph_ledger book = new;
    bit          sender_idles;
    bit          receiver_idles;
    int unsigned ready_hold;

    lcd_progress_bar_cells dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .glyph_valid (glyph_valid),
        .glyph_ready (glyph_ready),
        .glyph       (glyph)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(negedge clk)
    begin
        if (ready_hold != 0)
        begin
            glyph_ready = 1'b0;
            ready_hold--;
        end
        else
            glyph_ready = !(receiver_idles && $urandom_range(99) < 31);
    end

    always @(posedge clk)
    begin
        if (rst_n && glyph_valid && glyph_ready)
            book.check_glyph(glyph);
    end

    function automatic lpb_pkg::lpb_req_t bar_req(int unsigned p, int unsigned m,
                                                  int unsigned l);
        lpb_pkg::lpb_req_t r;
        r.progress   = lpb_pkg::PROGRESS_W'(p);
        r.full_scale = lpb_pkg::PROGRESS_W'(m);
        r.bar_length = lpb_pkg::LEN_W'(l);
        return r;
    endfunction

    function automatic lpb_pkg::lpb_req_t random_request();
        lpb_pkg::lpb_req_t r;
        int unsigned       pick;
        pick = $urandom_range(99);
        if (pick < 80)
            r.bar_length = lpb_pkg::LEN_W'($urandom_range(1, lpb_pkg::MAX_CELLS));
        else if (pick < 93)
            r.bar_length = lpb_pkg::LEN_W'($urandom_range(lpb_pkg::MAX_CELLS + 1, 31));
        else
            r.bar_length = '0;
        pick = $urandom_range(99);
        if (pick < 70)
            r.full_scale = lpb_pkg::PROGRESS_W'($urandom_range(1, 65535));
        else if (pick < 82)
            r.full_scale = lpb_pkg::PROGRESS_W'($urandom_range(1, 100));
        else if (pick < 90)
            r.full_scale = '0;
        else
            r.full_scale = '1;
        pick = $urandom_range(99);
        if (pick < 60 && r.full_scale != 0)
            r.progress = lpb_pkg::PROGRESS_W'($urandom_range(0, r.full_scale));
        else if (pick < 75)
            r.progress = r.full_scale;
        else if (pick < 90)
            r.progress = lpb_pkg::PROGRESS_W'($urandom_range(0, 65535));
        else
            r.progress = '0;
        return r;
    endfunction

    task automatic send_request(lpb_pkg::lpb_req_t r);
        while (sender_idles && $urandom_range(99) < 31)
            @(negedge clk);
        req       = r;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        book.note_request(r);
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic random_phase(int unsigned items);
        lpb_pkg::lpb_req_t r;
        int unsigned       sent;
        sent = 0;
        while (sent < items)
        begin
            r = random_request();
            send_request(r);
            if (r.bar_length != 0)
                sent++;
        end
    endtask

    task automatic drain();
        int unsigned waited;
        waited = 0;
        while (book.pending_glyphs.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
    endtask

    initial
    begin
        lpb_pkg::lpb_req_t directed[$];
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        glyph_ready    = 1'b0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        ready_hold     = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed = '{
            bar_req(0, 100, 16),
            bar_req(100, 100, 16),
            bar_req(50, 100, 16),
            bar_req(33, 100, 16),
            bar_req(40, 80, 16),
            bar_req(1, 3, 1),
            bar_req(2, 3, 1),
            bar_req(4, 5, 1),
            bar_req(1, 65535, 1),
            bar_req(65535, 65535, 16),
            bar_req(65534, 65535, 16),
            bar_req(65535, 1, 16),
            bar_req(200, 100, 3),
            bar_req(5, 0, 10),
            bar_req(0, 0, 1),
            bar_req(7, 9, 0),
            bar_req(12345, 54321, 31),
            bar_req(32768, 65535, 17),
            bar_req(32768, 65535, 7),
            bar_req(21845, 43690, 15),
            bar_req(10922, 21845, 8)
        };
        foreach (directed[k])
            send_request(directed[k]);

        random_phase(100);

        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        random_phase(80);

        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        ready_hold     = 400;
        random_phase(10);

        drain();
        random_phase(130);

        drain();
        repeat (40) @(negedge clk);
        book.close_out();
        if (book.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
